[hdl/mbn_pkg.sv]
package mbn_pkg;

  localparam int unsigned IndexBitsDefault     = 30;
  localparam int unsigned MaxDimensionsDefault = 3;
  localparam int unsigned MaxNeighborsDefault  = 27;

  localparam logic [1:0] ResetDimensions    = 2'd3;
  localparam logic [1:0] ResetRadiusSquared = 2'd3;
  localparam logic [30:0] ResetIndexCount   = 31'd1;

  typedef enum logic [1:0] {
    RegDimensions    = 2'd0,
    RegRadiusSquared = 2'd1,
    RegIndexCount    = 2'd2
  } reg_addr_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDrain,
    StEmpty
  } state_e;

  // control broadcast to every sort cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

[hdl/morton_ball_neighbors_top.sv]
// morton ball neighbour search
// input channel: box_index_i with box_valid_i / box_ready_o; one beat per request
// output channel: neighbor_index_o, is_last_o, none_found_o with out_valid_o / out_ready_i
// a request walks 27 offsets, one candidate per cycle, through a row of sort
// cells that hold the survivors in ascending order; then the cells shift
// their contents towards the output one beat per accepted result
// the first result is valid once the walk has passed all 27 offsets; a request
// delivers one beat per survivor, or one beat, the empty mark, if none survives
// the candidate walk, one offset a cycle, comes before any result
// apb registers: 0x0 dimensions, 0x4 radius_squared, 0x8 index_count
// reset: dimensions 3, radius_squared 3, index_count 1, cells empty
// a stalled receiver holds the head result; no new request is taken until
// the whole run has been delivered
module morton_ball_neighbors_top import mbn_pkg::*; #(
  parameter int unsigned INDEX_BITS     = IndexBitsDefault,
  parameter int unsigned MAX_DIMENSIONS = MaxDimensionsDefault,
  parameter int unsigned MAX_NEIGHBORS  = MaxNeighborsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  box_valid_i,
  output logic                  box_ready_o,
  input  logic [INDEX_BITS-1:0] box_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INDEX_BITS-1:0] neighbor_index_o,
  output logic                  is_last_o,
  output logic                  none_found_o
);

  localparam int unsigned NumOffsets = 27;

  logic [1:0]  dim_q;
  logic [1:0]  r2_q;
  logic [30:0] limit_q;
  state_e      state_q, state_d;
  logic [4:0]  offset_q, offset_d;
  logic        any_q, any_d;
  logic        load;
  logic        keep;
  logic [INDEX_BITS-1:0] code;
  cell_ctrl_t  ctrl;
  logic        out_fire;

  logic                  cv [MAX_NEIGHBORS+1];
  logic                  cg [MAX_NEIGHBORS+1];
  logic [INDEX_BITS-1:0] cval [MAX_NEIGHBORS+1];

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= ResetDimensions;
      r2_q    <= ResetRadiusSquared;
      limit_q <= ResetIndexCount;
    end else if (psel && penable && pwrite) begin
      case (reg_addr_e'(paddr[3:2]))
        RegDimensions:    dim_q   <= pwdata[1:0];
        RegRadiusSquared: r2_q    <= pwdata[1:0];
        RegIndexCount:    limit_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_addr_e'(paddr[3:2]))
      RegDimensions:    prdata = {30'd0, dim_q};
      RegRadiusSquared: prdata = {30'd0, r2_q};
      RegIndexCount:    prdata = {1'b0, limit_q};
      default:          prdata = '0;
    endcase
  end

  assign load     = box_valid_i && box_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  mbn_cand #(.IndexBits(INDEX_BITS), .MaxDimensions(MAX_DIMENSIONS)) u_cand (
    .clk_i, .rst_ni, .load_i(load), .box_i(box_index_i), .dim_i(dim_q),
    .r2max_i(r2_q), .limit_i(limit_q), .offset_i(offset_q),
    .keep_o(keep), .code_o(code)
  );

  always_comb begin
    state_d  = state_q;
    offset_d = offset_q;
    any_d    = any_q;
    case (state_q)
      StIdle: begin
        if (box_valid_i) begin
          state_d  = StWalk;
          offset_d = '0;
          any_d    = 1'b0;
        end
      end
      StWalk: begin
        offset_d = offset_q + 5'd1;
        if (keep) any_d = 1'b1;
        if (offset_q == 5'(NumOffsets - 1)) begin
          state_d = (any_q || keep) ? StDrain : StEmpty;
        end
      end
      StDrain: begin
        if (out_fire && is_last_o) state_d = StIdle;
      end
      StEmpty: begin
        if (out_fire) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    box_ready_o  = (state_q == StIdle);
    ctrl.clear   = load;
    ctrl.insert  = (state_q == StWalk) && keep;
    ctrl.shift   = (state_q == StDrain) && out_fire;
    out_valid_o  = (state_q == StDrain) || (state_q == StEmpty);
    none_found_o = (state_q == StEmpty);
    neighbor_index_o = (state_q == StEmpty) ? '0 : cval[1];
    is_last_o    = (state_q == StEmpty) ||
                   (MAX_NEIGHBORS == 1) || !cv[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      offset_q <= '0;
      any_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      any_q    <= any_d;
    end
  end

  // slot zero is a virtual always-full, never-greater head
  assign cv[0]   = 1'b1;
  assign cg[0]   = 1'b0;
  assign cval[0] = '0;

  for (genvar i = 1; i <= MAX_NEIGHBORS; i++) begin : g_cell
    logic                  nv;
    logic [INDEX_BITS-1:0] nval;
    if (i == MAX_NEIGHBORS) begin : g_end
      assign nv   = 1'b0;
      assign nval = '0;
    end else begin : g_mid
      assign nv   = cv[i+1];
      assign nval = cval[i+1];
    end
    mbn_cell #(.IndexBits(INDEX_BITS)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .key_i(code),
      .prev_valid_i(cv[i-1]), .prev_gt_i(cg[i-1]), .prev_value_i(cval[i-1]),
      .next_valid_i(nv), .next_value_i(nval),
      .valid_o(cv[i]), .gt_o(cg[i]), .value_o(cval[i])
    );
  end

  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> cv[1]) else $error("drain with empty head cell");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !box_ready_o) else $error("input taken while busy");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (offset_q < 5'(NumOffsets)))
    else $error("offset walk overran");

endmodule

[hdl/mbn_cand.sv]
// one candidate per cycle: offset digits in base three, per-dimension adjust, re-interleave
module mbn_cand import mbn_pkg::*; #(
  parameter int unsigned IndexBits     = IndexBitsDefault,
  parameter int unsigned MaxDimensions = MaxDimensionsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [IndexBits-1:0] box_i,
  input  logic [1:0]           dim_i,
  input  logic [1:0]           r2max_i,
  input  logic [30:0]          limit_i,
  input  logic [4:0]           offset_i,
  output logic                 keep_o,
  output logic [IndexBits-1:0] code_o
);

  // one spare bit so that a coordinate can step past the top of the code
  localparam int unsigned CoordBits = IndexBits + 1;

  logic [CoordBits-1:0] base_q [3];
  logic [CoordBits-1:0] base_d [3];
  logic [CoordBits-1:0] c      [3];
  logic [1:0]           digit  [3];
  logic [2:0]           used;
  logic [1:0]           r2;
  logic                 ok;
  logic [IndexBits:0]   k;
  logic [IndexBits:0]   lim;
  logic [1:0]           dm;
  logic [4:0]           rest;

  always_comb begin
    dm = (dim_i == 2'd0) ? 2'd1 :
         (dim_i > 2'(MaxDimensions)) ? 2'(MaxDimensions) : dim_i;
  end

  // de-interleave; the bit positions are fixed per dimension count
  always_comb begin
    for (int d = 0; d < 3; d++) base_d[d] = '0;
    for (int b = 0; b < IndexBits; b++) begin
      case (dm)
        2'd1:    base_d[0][b] = box_i[b];
        2'd2:    base_d[b % 2][b / 2] = box_i[b];
        default: base_d[b % 3][b / 3] = box_i[b];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 3; d++) base_q[d] <= '0;
    end else if (load_i) begin
      for (int d = 0; d < 3; d++) base_q[d] <= base_d[d];
    end
  end

  always_comb begin
    // base three digits of the offset number by compare and subtract
    if (offset_i >= 5'd18) begin
      digit[2] = 2'd2;
      rest     = offset_i - 5'd18;
    end else if (offset_i >= 5'd9) begin
      digit[2] = 2'd1;
      rest     = offset_i - 5'd9;
    end else begin
      digit[2] = 2'd0;
      rest     = offset_i;
    end
    if (rest >= 5'd6) begin
      digit[1] = 2'd2;
      rest     = rest - 5'd6;
    end else if (rest >= 5'd3) begin
      digit[1] = 2'd1;
      rest     = rest - 5'd3;
    end else begin
      digit[1] = 2'd0;
    end
    digit[0] = rest[1:0];
    used = {dm == 2'd3, dm >= 2'd2, 1'b1};
    r2 = '0;
    ok = 1'b1;
    for (int d = 0; d < 3; d++) begin
      c[d] = base_q[d];
      if (used[d]) begin
        if (digit[d] == 2'd0) begin
          r2 = r2 + 2'd1;
          if (base_q[d] == '0) ok = 1'b0;
          c[d] = base_q[d] - 1'b1;
        end else if (digit[d] == 2'd2) begin
          r2 = r2 + 2'd1;
          c[d] = base_q[d] + 1'b1;
        end
      end else begin
        // an unused dimension only takes part at its centre digit
        if (digit[d] != 2'd1) ok = 1'b0;
        c[d] = '0;
      end
    end
    k = '0;
    for (int d = 0; d < 3; d++) begin
      for (int p = 0; p < CoordBits; p++) begin
        if (used[d] && c[d][p]) begin
          if (p * dm + d > IndexBits) ok = 1'b0;
          else k[p * dm + d] = 1'b1;
        end
      end
    end
    lim = (limit_i > 31'(2 ** IndexBits)) ? (IndexBits+1)'(2 ** IndexBits)
                                          : (IndexBits+1)'(limit_i);
    if (k[IndexBits]) ok = 1'b0;
  end

  assign keep_o = ok && (r2 <= r2max_i) && (k < lim);
  assign code_o = k[IndexBits-1:0];

endmodule

[hdl/mbn_cell.sv]
// one slot of the insertion chain; on insert neighbours pass values upward, on shift towards the head
module mbn_cell import mbn_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [IndexBits-1:0] key_i,
  input  logic                 prev_valid_i,
  input  logic                 prev_gt_i,
  input  logic [IndexBits-1:0] prev_value_i,
  input  logic                 next_valid_i,
  input  logic [IndexBits-1:0] next_value_i,
  output logic                 valid_o,
  output logic                 gt_o,
  output logic [IndexBits-1:0] value_o
);

  logic                 valid_q, valid_d;
  logic [IndexBits-1:0] value_q, value_d;

  assign gt_o    = valid_q && (value_q > key_i);
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (gt_o) begin
        // larger entries move up one place
        if (prev_gt_i) value_d = prev_value_i;
        else           value_d = key_i;
      end else if (!valid_q && prev_valid_i) begin
        valid_d = 1'b1;
        value_d = prev_gt_i ? prev_value_i : key_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) value_q <= value_d;

endmodule
